// File: hw/rtl/skct_pkg.sv
// skct_pkg: shared types and constants of the sorted key count table
// no dependencies; imported by skct_cell, skct_chain and sorted_key_count_table_top
package skct_pkg;

  localparam int KEY_W   = 64;
  localparam int CNT_W   = 32;
  localparam int ENTRY_W = 9;

  // request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } skct_state_t;

  // broadcast from the controller to every cell of one chain
  typedef struct packed {
    logic             cmp;
    logic             add_hit;
    logic             insert;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] first_count;
    logic [CNT_W-1:0] add_count;
  } skct_ctrl_t;

  // lookup outcome of one chain
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] count;
  } skct_stat_t;

endpackage

// File: hw/rtl/skct_cell.sv
// skct_cell: one table slot holding key, count and entry number
// depends on skct_pkg; instantiated in a row by skct_chain
module skct_cell #(
  parameter int NUM_W = 8
) (
  input  logic                      clk,
  input  skct_pkg::skct_ctrl_t      ctrl,
  input  logic                      occ,
  input  logic [NUM_W-1:0]          new_num,
  input  logic                      prev_less,
  input  logic [skct_pkg::KEY_W-1:0] prev_key,
  input  logic [skct_pkg::CNT_W-1:0] prev_count,
  input  logic [NUM_W-1:0]          prev_num,
  output logic [skct_pkg::KEY_W-1:0] key,
  output logic [skct_pkg::CNT_W-1:0] count,
  output logic [NUM_W-1:0]          num,
  output logic                      less,
  output logic                      eq
);
  import skct_pkg::*;

  // compare flags, taken in the accept cycle
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      less <= occ && (key < ctrl.key);
      eq   <= occ && (key == ctrl.key);
    end
  end

  // slot contents: add on a hit, insert here or take the left neighbor's word
  always_ff @(posedge clk) begin
    if (ctrl.add_hit && eq) begin
      count <= count + ctrl.add_count;
    end else if (ctrl.insert && !less) begin
      if (prev_less) begin
        key   <= ctrl.key;
        count <= ctrl.first_count;
        num   <= new_num;
      end else begin
        key   <= prev_key;
        count <= prev_count;
        num   <= prev_num;
      end
    end
  end

endmodule

// File: hw/rtl/skct_chain.sv
// skct_chain: row of cells forming one sorted table, with the hit gather
// depends on skct_pkg and skct_cell
module skct_chain #(
  parameter int DEPTH  = 256,
  parameter int NUM_W  = 8,
  parameter int FILL_W = 9
) (
  input  logic                  clk,
  input  skct_pkg::skct_ctrl_t  ctrl,
  input  logic [FILL_W-1:0]     fill,
  input  logic [NUM_W-1:0]      new_num,
  output skct_pkg::skct_stat_t  stat,
  output logic [NUM_W-1:0]      hit_num
);
  import skct_pkg::*;

  logic [KEY_W-1:0] ck [DEPTH];
  logic [CNT_W-1:0] cc [DEPTH];
  logic [NUM_W-1:0] cn [DEPTH];
  logic             cl [DEPTH];
  logic             ceq [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             p_less;
    logic [KEY_W-1:0] p_key;
    logic [CNT_W-1:0] p_count;
    logic [NUM_W-1:0] p_num;

    if (i == 0) begin : g_head
      // head slot: everything to the left counts as smaller
      assign p_less  = 1'b1;
      assign p_key   = '0;
      assign p_count = '0;
      assign p_num   = '0;
    end else begin : g_body
      assign p_less  = cl[i-1];
      assign p_key   = ck[i-1];
      assign p_count = cc[i-1];
      assign p_num   = cn[i-1];
    end

    skct_cell #(
      .NUM_W (NUM_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (FILL_W'(i) < fill),
      .new_num    (new_num),
      .prev_less  (p_less),
      .prev_key   (p_key),
      .prev_count (p_count),
      .prev_num   (p_num),
      .key        (ck[i]),
      .count      (cc[i]),
      .num        (cn[i]),
      .less       (cl[i]),
      .eq         (ceq[i])
    );
  end

  // at most one occupied slot matches, so an and-or gather picks it
  always_comb begin
    stat    = '0;
    hit_num = '0;
    for (int i = 0; i < DEPTH; i++) begin
      stat.found = stat.found | ceq[i];
      stat.count = stat.count | (ceq[i] ? cc[i] : '0);
      hit_num    = hit_num | (ceq[i] ? cn[i] : '0);
    end
  end

endmodule

// File: hw/rtl/sorted_key_count_table_top.sv
// sorted_key_count_table_top: controller, fill counts and result register
// depends on skct_pkg and skct_chain (which holds skct_cell)
//
// In the cycle where start is high and busy is low the word is accepted and
// every slot of the addressed table compares its key with the request key in
// parallel; in the next cycle (busy high) the table is updated: on an add hit
// the matching slot adds add_count, on an add miss with room left every slot
// at or beyond the sorted position takes its left neighbor's word and the new
// key drops into place, all in one step. The result word is on hit,
// entry_number, count and table_full for exactly one cycle, marked by done,
// in the cycle after the update; a new request may be started in that same
// cycle, but not while busy, since the compare-then-shift pass through the
// cell row must finish first. The receiver cannot stall: it must take the
// result in its done cycle. Keys are truncated to KEY_CHARS characters and
// cut at the first zero character before use. table_sel is folded modulo
// TABLES. Reset clears the state, done and the fill counts; slot contents
// are never read before they are written.
module sorted_key_count_table_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int TABLES      = 4,
  parameter int KEY_CHARS   = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type,
  input  logic [1:0]                        table_sel,
  input  logic [skct_pkg::KEY_W-1:0]        key,
  input  logic signed [skct_pkg::CNT_W-1:0] first_count,
  input  logic signed [skct_pkg::CNT_W-1:0] add_count,
  output logic                              done,
  output logic                              hit,
  output logic [skct_pkg::ENTRY_W-1:0]      entry_number,
  output logic signed [skct_pkg::CNT_W-1:0] count,
  output logic                              table_full
);
  import skct_pkg::*;

  localparam int NUM_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int TAB_W  = (TABLES > 1) ? $clog2(TABLES) : 1;

  skct_state_t state, state_next;

  // request held for the update cycle
  logic              req_q;
  logic [TAB_W-1:0]  tab_q;
  logic [KEY_W-1:0]  key_q;
  logic [CNT_W-1:0]  first_q;
  logic [CNT_W-1:0]  add_q;
  logic [FILL_W-1:0] n_q;

  logic [FILL_W-1:0] fill [TABLES];

  logic [KEY_W-1:0]  knorm;
  logic [TAB_W-1:0]  tab_in;
  logic              accept;

  skct_stat_t        stat [TABLES];
  logic [NUM_W-1:0]  hnum [TABLES];

  logic              upd;
  logic              is_add;
  logic              found;
  logic              room;
  logic              do_add_hit;
  logic              do_insert;

  // key normalization: keep characters up to the first zero, at most KEY_CHARS
  always_comb begin
    logic       keep;
    logic [7:0] ch;
    knorm = '0;
    keep  = 1'b1;
    for (int i = 0; i < 8; i++) begin
      ch = key[KEY_W-1-8*i -: 8];
      if (i >= KEY_CHARS || ch == 8'd0) begin
        keep = 1'b0;
      end
      if (keep) begin
        knorm[KEY_W-1-8*i -: 8] = ch;
      end
    end
  end

  // table select folded into range
  always_comb begin
    logic [2:0] t;
    t = {1'b0, table_sel};
    for (int j = 0; j < 3; j++) begin
      if (32'(t) >= TABLES) begin
        t = t - 3'(TABLES);
      end
    end
    tab_in = TAB_W'(t);
  end

  assign accept = start && (state == ST_IDLE);
  assign upd    = (state == ST_UPD);
  assign is_add = (req_q == REQ_ADD);
  assign found  = stat[tab_q].found;
  assign room   = (n_q < FILL_W'(TABLE_DEPTH));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    do_add_hit = 1'b0;
    do_insert  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        busy       = 1'b1;
        do_add_hit = is_add && found;
        do_insert  = is_add && !found && room;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req_type;
      tab_q   <= tab_in;
      key_q   <= knorm;
      first_q <= first_count;
      add_q   <= add_count;
      n_q     <= fill[tab_in];
    end
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TABLES; t++) begin
        fill[t] <= '0;
      end
    end else if (do_insert) begin
      fill[tab_q] <= n_q + FILL_W'(1);
    end
  end

  // one cell row per table; only the addressed row updates
  for (genvar t = 0; t < TABLES; t++) begin : g_table
    skct_ctrl_t ctrl;

    always_comb begin
      ctrl.cmp         = accept;
      ctrl.add_hit     = do_add_hit && (tab_q == TAB_W'(t));
      ctrl.insert      = do_insert && (tab_q == TAB_W'(t));
      ctrl.key         = upd ? key_q : knorm;
      ctrl.first_count = first_q;
      ctrl.add_count   = add_q;
    end

    skct_chain #(
      .DEPTH  (TABLE_DEPTH),
      .NUM_W  (NUM_W),
      .FILL_W (FILL_W)
    ) u_chain (
      .clk     (clk),
      .ctrl    (ctrl),
      .fill    (fill[t]),
      .new_num (NUM_W'(n_q)),
      .stat    (stat[t]),
      .hit_num (hnum[t])
    );
  end

  // result word, valid for one cycle after the update
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      hit        <= found;
      table_full <= is_add && !found && !room;
      if (!is_add) begin
        entry_number <= '0;
      end else if (found) begin
        entry_number <= ENTRY_W'(hnum[tab_q]);
      end else begin
        entry_number <= ENTRY_W'(n_q);
      end
      count <= (!is_add && found) ? stat[tab_q].count : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_upd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPD))
    else $error("result strobe without an update cycle");

  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted request gave no result two cycles later");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    upd |-> (n_q <= FILL_W'(TABLE_DEPTH)))
    else $error("fill count beyond table depth");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    !(do_add_hit && do_insert))
    else $error("add hit and insert in the same update");

  a_full_miss: assert property (@(posedge clk) disable iff (rst)
    done |-> !(table_full && hit))
    else $error("table full reported on a hit");
`endif

endmodule
